@@ hw/rtl/skq_pkg.sv @@
// ----------------------------------------------------------------------------
// skq_pkg
// Shared types and constants for the sorted key queue.
// ----------------------------------------------------------------------------
package skq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int KEY_W = 32;
	localparam int DATA_W = 32;
	localparam int COUNT_W = 5;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		CMD_PREPEND = 2'd0,
		CMD_INSERT  = 2'd1,
		CMD_REMOVE  = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RSVD  = 2'd3
	} status_t;

	localparam key_t KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

	// controller to datapath commands
	typedef struct packed {
		logic load;   // latch input item and slot compare vector
		logic apply;  // update store, load result register
	} dp_cmd_t;

endpackage

@@ hw/rtl/skq_ctrl.sv @@
// ----------------------------------------------------------------------------
// skq_ctrl
// Two-state sequencer: take an item, then apply it once the result
// register is free.
// ----------------------------------------------------------------------------
module skq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output skq_pkg::dp_cmd_t dp_cmd
);
	import skq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_BUSY = 2'b10
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	assign dp_cmd.load  = s_tvalid && (state_q == S_IDLE);
	assign dp_cmd.apply = (state_q == S_BUSY) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_BUSY;
				end
				S_BUSY: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (dp_cmd.apply) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/skq_datapath.sv @@
// ----------------------------------------------------------------------------
// skq_datapath
// Entry registers with parallel slot compare and parallel shift, fill
// counter and result register.
// ----------------------------------------------------------------------------
module skq_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  skq_pkg::dp_cmd_t              dp_cmd,
	input  skq_pkg::cmd_t                 in_cmd,
	input  skq_pkg::key_t                 in_key,
	input  skq_pkg::data_t                in_data,
	output skq_pkg::status_t              out_status,
	output skq_pkg::key_t                 out_key,
	output skq_pkg::data_t                out_data,
	output logic [skq_pkg::COUNT_W-1:0]   out_count
);
	import skq_pkg::*;

	key_t    key_q   [DEPTH];
	data_t   data_q  [DEPTH];
	key_t    key_nx  [DEPTH];
	data_t   data_nx [DEPTH];
	cnt_t    fill_q;
	cnt_t    fill_nx;

	cmd_t    cmd_q;
	key_t    key_in_q;
	data_t   data_in_q;
	logic [DEPTH-1:0] mv_q;   // thermometer: entry i sits at or above the new slot
	logic [DEPTH-1:0] mv_d;

	status_t status_q;
	key_t    okey_q;
	data_t   odata_q;

	logic    full;
	logic    empty;
	key_t    new_key;

	assign full  = (fill_q == CNT_W'(DEPTH));
	assign empty = (fill_q == '0);

	// slot search on the incoming key (prepend marks every slot); stored keys are ascending so the
	// "not less" flags over held entries already form a thermometer
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (in_cmd == CMD_PREPEND) begin
				mv_d[i] = 1'b1;
			end else begin
				mv_d[i] = (CNT_W'(i) >= fill_q) || !(key_q[i] < in_key);
			end
		end
	end

	// prepend key is head key minus one, saturating at the most negative value (zero when empty)
	always_comb begin
		if (cmd_q == CMD_PREPEND) begin
			if (empty) begin
				new_key = '0;
			end else if (key_q[0] == KEY_MIN) begin
				new_key = KEY_MIN;
			end else begin
				new_key = key_q[0] - key_t'(1);
			end
		end else begin
			new_key = key_in_q;
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			key_nx[i]  = key_q[i];
			data_nx[i] = data_q[i];
		end
		fill_nx = fill_q;
		unique case (cmd_q)
			CMD_PREPEND, CMD_INSERT: begin
				if (!full) begin
					if (mv_q[0]) begin
						key_nx[0]  = new_key;
						data_nx[0] = data_in_q;
					end
					for (int i = 1; i < DEPTH; i++) begin
						if (mv_q[i] && !mv_q[i-1]) begin
							key_nx[i]  = new_key;
							data_nx[i] = data_in_q;
						end else if (mv_q[i]) begin
							key_nx[i]  = key_q[i-1];
							data_nx[i] = data_q[i-1];
						end
					end
					fill_nx = fill_q + cnt_t'(1);
				end
			end
			CMD_REMOVE: begin
				if (!empty) begin
					for (int i = 0; i < DEPTH - 1; i++) begin
						key_nx[i]  = key_q[i+1];
						data_nx[i] = data_q[i+1];
					end
					fill_nx = fill_q - cnt_t'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q     <= in_cmd;
			key_in_q  <= in_key;
			data_in_q <= in_data;
			mv_q      <= mv_d;
		end
		if (dp_cmd.apply) begin
			for (int i = 0; i < DEPTH; i++) begin
				key_q[i]  <= key_nx[i];
				data_q[i] <= data_nx[i];
			end
			status_q <= STAT_OK;
			okey_q   <= '0;
			odata_q  <= '0;
			unique case (cmd_q)
				CMD_PREPEND, CMD_INSERT: begin
					if (full) status_q <= STAT_FULL;
				end
				CMD_REMOVE: begin
					if (empty) begin
						status_q <= STAT_EMPTY;
						okey_q   <= '1;
					end else begin
						okey_q  <= key_q[0];
						odata_q <= data_q[0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (dp_cmd.apply) begin
			fill_q <= fill_nx;
		end
	end

	assign out_status = status_q;
	assign out_key    = okey_q;
	assign out_data   = odata_q;
	assign out_count  = COUNT_W'(fill_q);

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.apply && cmd_q == CMD_REMOVE && empty
		|=> fill_q == '0 && status_q == STAT_EMPTY)
		else $error("remove on empty queue changed state");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.apply && (cmd_q == CMD_PREPEND || cmd_q == CMD_INSERT) && !full
		|=> fill_q == $past(fill_q) + cnt_t'(1))
		else $error("add did not grow the queue");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q >= cnt_t'(2) |-> key_q[0] <= key_q[1])
		else $error("head entries out of order");

endmodule

@@ hw/rtl/sorted_key_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_key_queue_core
// Bounded priority queue of key/data entries held in ascending key order.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ stream: s_tuser selects prepend, sorted insert,
//   remove head or no-op; s_tdata carries the key and the data word. Every command
//   yields exactly one result transfer on the m_ stream: status in m_tuser,
//   removed key, removed data and the entry count after the step in m_tdata.
//   A command is compared on entry in the idle state, then applied in the
//   busy state by a shift that updates all entries in parallel and loads the
//   result register; no new command is taken until the busy state is left.
//   When the receiver stalls, the result holds; the core takes one more
//   command and holds it until the result register frees up.
//   Reset empties the queue at once; stored entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_key_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] key, [63:32] data
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [31:0] out_key, [63:32] out_data, [68:64] count, zero pad
	output logic [1:0]  m_tuser    // [1:0] status
);
	import skq_pkg::*;

	dp_cmd_t              dp_cmd;
	status_t              out_status;
	key_t                 out_key;
	data_t                out_data;
	logic [COUNT_W-1:0]   out_count;

	skq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dp_cmd   (dp_cmd)
	);

	skq_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.dp_cmd     (dp_cmd),
		.in_cmd     (cmd_t'(s_tuser)),
		.in_key     (key_t'(s_tdata[31:0])),
		.in_data    (data_t'(s_tdata[63:32])),
		.out_status (out_status),
		.out_key    (out_key),
		.out_data   (out_data),
		.out_count  (out_count)
	);

	assign m_tuser = out_status;
	assign m_tdata = {3'b000, out_count, out_data, out_key};

endmodule
